FILE: src/gpd_pkg.sv
`timescale 1ns / 1ps

package gpd_pkg;

	localparam int MAX_ROWS = 32;
	localparam int MAX_COLS = 32;
	localparam int ROW_W = 5;
	localparam int COL_W = 5;
	localparam int H_W = 16;
	localparam int CFG_W = 6;
	localparam int CFG_IDX_W = 1;
	localparam int LINES = 3;
	localparam int LINE_W = 2;
	localparam int RAM_DEPTH = LINES * MAX_COLS;
	localparam int RAM_AW = $clog2(RAM_DEPTH);
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [CFG_W-1:0] MAX_ROWS_C = CFG_W'(MAX_ROWS);
	localparam logic [CFG_W-1:0] MAX_COLS_C = CFG_W'(MAX_COLS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_ROWS = 1'b0,
		REG_GRID_COLS = 1'b1
	} cfg_reg_t;

	typedef logic signed [H_W-1:0] height_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic up_ok;
		logic dn_ok;
		logic lf_ok;
		logic rt_ok;
		logic fin;
		height_t up;
		height_t mid;
		height_t dn;
		height_t lf;
		height_t rt;
	} task_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic peak;
		logic fin;
	} verdict_t;

	typedef struct packed {
		logic we;
		logic [RAM_AW-1:0] waddr;
		logic [H_W-1:0] wdata;
		logic [RAM_AW-1:0] raddr_a;
		logic [RAM_AW-1:0] raddr_b;
		logic [RAM_AW-1:0] raddr_c;
		logic [RAM_AW-1:0] raddr_d;
	} ram_req_t;

	function automatic logic [CFG_W-1:0] eff_size(logic [CFG_W-1:0] v, logic [CFG_W-1:0] maxv);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [LINE_W-1:0] line_prev(logic [LINE_W-1:0] l);
		logic [LINE_W-1:0] r;
		case (l)
			LINE_W'(0): r = LINE_W'(2);
			LINE_W'(1): r = LINE_W'(0);
			default:    r = LINE_W'(1);
		endcase
		return r;
	endfunction

	function automatic logic [LINE_W-1:0] line_next(logic [LINE_W-1:0] l);
		logic [LINE_W-1:0] r;
		case (l)
			LINE_W'(0): r = LINE_W'(1);
			LINE_W'(1): r = LINE_W'(2);
			default:    r = LINE_W'(0);
		endcase
		return r;
	endfunction

	function automatic verdict_t judge(task_t t);
		verdict_t v;
		logic beaten;
		beaten = (t.up_ok && ($signed(t.mid) < $signed(t.up)))
			|| (t.dn_ok && ($signed(t.mid) < $signed(t.dn)))
			|| (t.lf_ok && ($signed(t.mid) < $signed(t.lf)))
			|| (t.rt_ok && ($signed(t.mid) < $signed(t.rt)));
		v.row = t.row;
		v.col = t.col;
		v.peak = !beaten;
		v.fin = t.fin;
		return v;
	endfunction

endpackage

FILE: src/gpd_if.sv
`timescale 1ns / 1ps

interface gpd_in_if;
	logic valid;
	logic ready;
	gpd_pkg::height_t height;

	modport source (output valid, output height, input ready);
	modport sink (input valid, input height, output ready);
endinterface

interface gpd_res_if;
	logic valid;
	logic ready;
	logic [gpd_pkg::ROW_W-1:0] cell_row;
	logic [gpd_pkg::COL_W-1:0] cell_col;
	logic is_peak;
	logic frame_last;

	modport source (output valid, output cell_row, output cell_col, output is_peak,
		output frame_last, input ready);
	modport sink (input valid, input cell_row, input cell_col, input is_peak,
		input frame_last, output ready);
endinterface

FILE: src/gpd_ram.sv
`timescale 1ns / 1ps

module gpd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 96
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: src/gpd_queue.sv
`timescale 1ns / 1ps

module gpd_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  gpd_pkg::task_t             push_data,
	input  logic                       pop,
	output logic                       head_valid,
	output gpd_pkg::task_t             head_data,
	output logic [gpd_pkg::Q_CNT_W-1:0] count
);
	import gpd_pkg::*;

	task_t               slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  count_q;

	assign head_valid = (count_q != '0);
	assign head_data = slot_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= Q_PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= Q_PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= Q_CNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= Q_CNT_W'(count_q - 1'b1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != Q_CNT_W'(Q_DEPTH)))
		else $error("Queue written while full.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("Queue read while empty.");

endmodule

FILE: src/gpd_front.sv
`timescale 1ns / 1ps

module gpd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	gpd_in_if.sink                        cells,
	input  logic                          cfg_we,
	input  logic [gpd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [gpd_pkg::CFG_W-1:0]     cfg_data,
	output gpd_pkg::ram_req_t             ram_req,
	input  logic [gpd_pkg::H_W-1:0]       ram_rdata_a,
	input  logic [gpd_pkg::H_W-1:0]       ram_rdata_b,
	input  logic [gpd_pkg::H_W-1:0]       ram_rdata_c,
	input  logic [gpd_pkg::H_W-1:0]       ram_rdata_d,
	input  logic [gpd_pkg::Q_CNT_W-1:0]   q_count,
	output logic                          push,
	output gpd_pkg::task_t                push_data
);
	import gpd_pkg::*;

	logic [CFG_W-1:0]  rows_q;
	logic [CFG_W-1:0]  cols_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [LINE_W-1:0] line_q;
	logic              flush_q;
	logic [COL_W-1:0]  fl_col_q;
	logic [ROW_W-1:0]  fl_row_q;
	logic [LINE_W-1:0] fl_line_q;
	logic [LINE_W-1:0] fl_upl_q;
	logic              valid_s1;
	task_t             task_s1;

	logic [CFG_W-1:0]  nr;
	logic [CFG_W-1:0]  nc;
	logic [LINE_W-1:0] line_m1;
	logic [LINE_W-1:0] line_m2;
	logic              room;
	logic              acc;
	logic              row_end;
	logic              last_row;
	logic              fl_go;
	logic              fl_end;

	assign nr = eff_size(rows_q, MAX_ROWS_C);
	assign nc = eff_size(cols_q, MAX_COLS_C);
	assign line_m1 = line_prev(line_q);
	assign line_m2 = line_prev(line_m1);

	// Space is reserved for the item already in the read stage.
	assign room = (Q_CNT_W'(q_count + Q_CNT_W'(valid_s1)) < Q_CNT_W'(Q_DEPTH));
	assign cells.ready = !flush_q && room;
	assign acc = cells.valid && cells.ready;
	assign fl_go = flush_q && room;

	assign row_end = ({1'b0, col_q} == CFG_W'(nc - 1'b1));
	assign last_row = ({1'b0, row_q} == CFG_W'(nr - 1'b1));
	assign fl_end = ({1'b0, fl_col_q} == CFG_W'(nc - 1'b1));

	always_comb begin
		ram_req.we = acc;
		ram_req.waddr = {line_q, col_q};
		ram_req.wdata = cells.height;
		if (flush_q) begin
			ram_req.raddr_a = {fl_line_q, fl_col_q};
			ram_req.raddr_b = {fl_upl_q, fl_col_q};
			ram_req.raddr_c = {fl_line_q, COL_W'(fl_col_q - 1'b1)};
			ram_req.raddr_d = {fl_line_q, COL_W'(fl_col_q + 1'b1)};
		end else begin
			ram_req.raddr_a = {line_m1, col_q};
			ram_req.raddr_b = {line_m2, col_q};
			ram_req.raddr_c = {line_m1, COL_W'(col_q - 1'b1)};
			ram_req.raddr_d = {line_m1, COL_W'(col_q + 1'b1)};
		end
	end

	always_comb begin
		push = valid_s1;
		push_data = task_s1;
		push_data.mid = ram_rdata_a;
		push_data.up = ram_rdata_b;
		push_data.lf = ram_rdata_c;
		push_data.rt = ram_rdata_d;
	end

	always_ff @(posedge clk) begin
		if (fl_go) begin
			task_s1.row <= fl_row_q;
			task_s1.col <= fl_col_q;
			task_s1.up_ok <= (fl_row_q != '0);
			task_s1.dn_ok <= 1'b0;
			task_s1.lf_ok <= (fl_col_q != '0);
			task_s1.rt_ok <= !fl_end;
			task_s1.fin <= fl_end;
			task_s1.dn <= '0;
		end else if (acc) begin
			task_s1.row <= ROW_W'(row_q - 1'b1);
			task_s1.col <= col_q;
			task_s1.up_ok <= (row_q > ROW_W'(1));
			task_s1.dn_ok <= 1'b1;
			task_s1.lf_ok <= (col_q != '0);
			task_s1.rt_ok <= !row_end;
			task_s1.fin <= 1'b0;
			task_s1.dn <= cells.height;
		end
		task_s1.up <= '0;
		task_s1.mid <= '0;
		task_s1.lf <= '0;
		task_s1.rt <= '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= MAX_ROWS_C;
			cols_q <= MAX_COLS_C;
			row_q <= '0;
			col_q <= '0;
			line_q <= '0;
			flush_q <= 1'b0;
			fl_col_q <= '0;
			fl_row_q <= '0;
			fl_line_q <= '0;
			fl_upl_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= fl_go || (acc && (row_q != '0));
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_idx))
					REG_GRID_ROWS: rows_q <= cfg_data;
					REG_GRID_COLS: cols_q <= cfg_data;
					default: ;
				endcase
				row_q <= '0;
				col_q <= '0;
				line_q <= '0;
			end else if (acc) begin
				if (row_end) begin
					col_q <= '0;
					if (last_row) begin
						row_q <= '0;
						line_q <= '0;
					end else begin
						row_q <= ROW_W'(row_q + 1'b1);
						line_q <= line_next(line_q);
					end
				end else begin
					col_q <= COL_W'(col_q + 1'b1);
				end
			end
			if (acc && row_end && last_row) begin
				flush_q <= 1'b1;
				fl_col_q <= '0;
				fl_row_q <= row_q;
				fl_line_q <= line_q;
				fl_upl_q <= line_m1;
			end else if (fl_go) begin
				if (fl_end) begin
					flush_q <= 1'b0;
				end else begin
					fl_col_q <= COL_W'(fl_col_q + 1'b1);
				end
			end
		end
	end

	a_flush_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> ({1'b0, fl_col_q} < nc))
		else $error("Last-row sweep ran past the final column.");

endmodule

FILE: src/gpd_back.sv
`timescale 1ns / 1ps

module gpd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  gpd_pkg::task_t q_data,
	output logic           pop,
	gpd_res_if.source      verdicts
);
	import gpd_pkg::*;

	verdict_t out_q;
	logic     ovalid_q;

	logic     out_free;

	assign out_free = !ovalid_q || verdicts.ready;
	assign pop = q_valid && out_free;

	assign verdicts.valid = ovalid_q;
	assign verdicts.cell_row = out_q.row;
	assign verdicts.cell_col = out_q.col;
	assign verdicts.is_peak = out_q.peak;
	assign verdicts.frame_last = out_q.fin;

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= judge(q_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else begin
			if (pop) begin
				ovalid_q <= 1'b1;
			end else if (verdicts.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	a_verdict_held: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !verdicts.ready) |=> (ovalid_q && $stable(out_q)))
		else $error("Verdict changed while the receiver stalled.");

endmodule

FILE: src/grid_peak_detector_unit.sv
`timescale 1ns / 1ps

// Channel    Role    Handshake       Payload
// cells      sink    valid/ready     height (16-bit signed, raster order)
// verdicts   source  valid/ready     cell_row, cell_col, is_peak, frame_last
// cfg        write   cfg_we          cfg_idx (register), cfg_data (6 bits)
//
// One cell is taken per cycle while ready is high; the cell above is judged via the queue.
// Two line store copies read a cell and its upper, left and right neighbours at once.
// After the final cell the front end sweeps the last row from the line store, one column
// per cycle while the queue has room, and holds cells not ready meanwhile.
// Reset clears the counters and sets a 32 by 32 grid; the line store is not cleared.
// A four-entry queue lets the output stall without stopping the input at once.

module grid_peak_detector_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	gpd_in_if.sink                        cells,
	gpd_res_if.source                     verdicts,
	input  logic                          cfg_we,
	input  logic [gpd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [gpd_pkg::CFG_W-1:0]     cfg_data
);
	import gpd_pkg::*;

	ram_req_t            ram_req;
	logic [H_W-1:0]      ram_rdata_a;
	logic [H_W-1:0]      ram_rdata_b;
	logic [H_W-1:0]      ram_rdata_c;
	logic [H_W-1:0]      ram_rdata_d;
	logic [Q_CNT_W-1:0]  q_count;
	logic                push;
	task_t               push_data;
	logic                pop;
	logic                q_valid;
	task_t               q_data;

	gpd_ram #(
		.WIDTH(H_W),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_req.we),
		.waddr   (ram_req.waddr),
		.wdata   (ram_req.wdata),
		.raddr_a (ram_req.raddr_a),
		.raddr_b (ram_req.raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	gpd_ram #(
		.WIDTH(H_W),
		.DEPTH(RAM_DEPTH)
	) u_ram_nb (
		.clk     (clk),
		.we      (ram_req.we),
		.waddr   (ram_req.waddr),
		.wdata   (ram_req.wdata),
		.raddr_a (ram_req.raddr_c),
		.raddr_b (ram_req.raddr_d),
		.rdata_a (ram_rdata_c),
		.rdata_b (ram_rdata_d)
	);

	gpd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cells       (cells),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.ram_req     (ram_req),
		.ram_rdata_a (ram_rdata_a),
		.ram_rdata_b (ram_rdata_b),
		.ram_rdata_c (ram_rdata_c),
		.ram_rdata_d (ram_rdata_d),
		.q_count     (q_count),
		.push        (push),
		.push_data   (push_data)
	);

	gpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.head_valid (q_valid),
		.head_data  (q_data),
		.count      (q_count)
	);

	gpd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.pop      (pop),
		.verdicts (verdicts)
	);

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

class peak_board;
	gpd_pkg::height_t lines [3][gpd_pkg::MAX_COLS];
	int unsigned next_row;
	int unsigned next_col;
	logic [gpd_pkg::CFG_W-1:0] rows_reg;
	logic [gpd_pkg::CFG_W-1:0] cols_reg;
	gpd_pkg::verdict_t due[$];
	int errors;

	function new();
		foreach (lines[l, c]) lines[l][c] = '0;
		next_row = 0;
		next_col = 0;
		rows_reg = gpd_pkg::CFG_W'(32);
		cols_reg = gpd_pkg::CFG_W'(32);
		errors = 0;
	endfunction

	function int unsigned span(logic [gpd_pkg::CFG_W-1:0] v, int unsigned lim);
		if (v == '0) begin
			return 1;
		end
		if (v > lim) begin
			return lim;
		end
		return v;
	endfunction

	function int unsigned cells_per_frame();
		return span(rows_reg, gpd_pkg::MAX_ROWS) * span(cols_reg, gpd_pkg::MAX_COLS);
	endfunction

	// Any register write starts a fresh frame.
	function void write_reg(gpd_pkg::cfg_reg_t idx, logic [gpd_pkg::CFG_W-1:0] val);
		if (idx == gpd_pkg::REG_GRID_ROWS) begin
			rows_reg = val;
		end else begin
			cols_reg = val;
		end
		next_row = 0;
		next_col = 0;
	endfunction

	function gpd_pkg::verdict_t verdict_for(int unsigned i, int unsigned j,
			int unsigned nr, int unsigned nc);
		gpd_pkg::verdict_t v;
		gpd_pkg::height_t h;
		h = lines[i % 3][j];
		v.peak = 1'b1;
		if (i >= 1 && h < lines[(i - 1) % 3][j]) begin
			v.peak = 1'b0;
		end
		if (i + 1 < nr && h < lines[(i + 1) % 3][j]) begin
			v.peak = 1'b0;
		end
		if (j >= 1 && h < lines[i % 3][j - 1]) begin
			v.peak = 1'b0;
		end
		if (j + 1 < nc && h < lines[i % 3][j + 1]) begin
			v.peak = 1'b0;
		end
		v.row = gpd_pkg::ROW_W'(i);
		v.col = gpd_pkg::COL_W'(j);
		v.fin = (i + 1 == nr) && (j + 1 == nc);
		return v;
	endfunction

	function void note_cell(gpd_pkg::height_t h);
		int unsigned nr;
		int unsigned nc;
		int unsigned r;
		int unsigned c;
		nr = span(rows_reg, gpd_pkg::MAX_ROWS);
		nc = span(cols_reg, gpd_pkg::MAX_COLS);
		r = (next_row >= nr) ? nr - 1 : next_row;
		c = (next_col >= nc) ? nc - 1 : next_col;
		lines[r % 3][c] = h;
		if (r >= 1) begin
			due.push_back(verdict_for(r - 1, c, nr, nc));
		end
		if (r + 1 == nr && c + 1 == nc) begin
			for (int unsigned j = 0; j < nc; j++) begin
				due.push_back(verdict_for(r, j, nr, nc));
			end
		end
		c++;
		if (c >= nc) begin
			c = 0;
			r++;
			if (r >= nr) begin
				r = 0;
			end
		end
		next_row = r;
		next_col = c;
	endfunction

	function void check_verdict(gpd_pkg::verdict_t got);
		gpd_pkg::verdict_t want;
		if (due.size() == 0) begin
			$display("%0t: unexpected verdict row %0d col %0d peak %0b last %0b",
				$time, got.row, got.col, got.peak, got.fin);
			errors++;
			return;
		end
		want = due.pop_front();
		if (got !== want) begin
			$display("%0t: verdict mismatch: expected row %0d col %0d peak %0b last %0b",
				$time, want.row, want.col, want.peak, want.fin);
			$display("%0t:                   actual row %0d col %0d peak %0b last %0b",
				$time, got.row, got.col, got.peak, got.fin);
			errors++;
		end
	endfunction
endclass

module tb;
	import gpd_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 16;
	localparam int TARGET_CELLS = 200;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	gpd_in_if cells ();
	gpd_res_if verdicts ();

	peak_board board;
	int quiet = 0;
	int burst_left = 0;
	int gap_max = 0;

	grid_peak_detector_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cells(cells),
		.verdicts(verdicts),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				board.write_reg(cfg_reg_t'(cfg_idx), cfg_data);
			end
			if (cells.valid && cells.ready) begin
				board.note_cell(cells.height);
			end
			if (verdicts.valid && verdicts.ready) begin
				board.check_verdict(verdict_t'{verdicts.cell_row, verdicts.cell_col,
					verdicts.is_peak, verdicts.frame_last});
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (cells.valid && cells.ready)
				|| (verdicts.valid && verdicts.ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// The receiver takes verdicts in runs, broken by stalls of random length.
	initial begin
		int run;
		int stall;
		verdicts.ready = 1'b1;
		forever begin
			run = $urandom_range(1, 24);
			verdicts.ready = 1'b1;
			repeat (run) @(negedge clk);
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (stall > 0) begin
				verdicts.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		@(negedge clk);
	endtask

	task automatic feed_cell(input height_t h);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (gap > 0) begin
				cells.valid = 1'b0;
				cells.height = height_t'($urandom);
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		cells.valid = 1'b1;
		cells.height = h;
		do @(posedge clk); while (!cells.ready);
		@(negedge clk);
	endtask

	task automatic settle();
		cells.valid = 1'b0;
		while (board.due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic height_t pick_height(int mode);
		case (mode)
			0: return height_t'($urandom);
			1: return height_t'(int'($urandom_range(0, 4)) - 2);
			default: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh0000;
					default: return height_t'($urandom);
				endcase
			end
		endcase
	endfunction

	initial begin
		int sent;
		int phase;
		int count;
		int frame_cells;
		int mode;
		int which;
		logic [CFG_W-1:0] rows;
		logic [CFG_W-1:0] cols;
		logic [CFG_W-1:0] eff_rows;
		logic [CFG_W-1:0] eff_cols;

		board = new;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_GRID_ROWS;
		cfg_data = '0;
		cells.valid = 1'b0;
		cells.height = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Part of a frame at the reset size; the write that follows restarts the frame.
		repeat (5) feed_cell(height_t'($urandom));
		settle();

		write_reg(REG_GRID_ROWS, '0);
		write_reg(REG_GRID_COLS, '0);
		feed_cell(16'sh7FFF);
		feed_cell(16'sh8000);
		settle();

		write_reg(REG_GRID_ROWS, CFG_W'(1));
		write_reg(REG_GRID_COLS, CFG_W'(4));
		feed_cell(16'sd5);
		feed_cell(16'sd5);
		feed_cell(-16'sd3);
		feed_cell(16'sh7FFF);
		settle();

		write_reg(REG_GRID_ROWS, CFG_W'(3));
		write_reg(REG_GRID_COLS, CFG_W'(3));
		feed_cell(16'sd0);
		feed_cell(16'sd1);
		feed_cell(16'sd0);
		feed_cell(16'sd1);
		feed_cell(16'sd1);
		feed_cell(16'sd1);
		feed_cell(16'sh8000);
		feed_cell(16'sd1);
		feed_cell(-16'sd1);
		settle();

		write_reg(REG_GRID_ROWS, CFG_W'(2));
		write_reg(REG_GRID_COLS, CFG_W'(1));
		feed_cell(-16'sd1);
		feed_cell(-16'sd1);
		settle();

		sent = 0;
		phase = 0;
		while (sent < TARGET_CELLS) begin
			which = 0;
			if (phase == 0) begin
				rows = CFG_W'(63);
				cols = CFG_W'(1);
			end else if (phase == 1) begin
				rows = CFG_W'(2);
				cols = CFG_W'(63);
			end else begin
				which = $urandom_range(0, 2);
				case ($urandom_range(0, 9))
					0: begin
						rows = CFG_W'($urandom_range(32, 63));
						cols = CFG_W'($urandom_range(0, 2));
					end
					1: begin
						rows = CFG_W'($urandom_range(0, 2));
						cols = CFG_W'($urandom_range(32, 63));
					end
					2: begin
						rows = '0;
						cols = CFG_W'($urandom_range(0, 6));
					end
					default: begin
						rows = CFG_W'($urandom_range(1, 6));
						cols = CFG_W'($urandom_range(1, 6));
					end
				endcase
			end
			eff_rows = (which == 2) ? board.rows_reg : rows;
			eff_cols = (which == 1) ? board.cols_reg : cols;
			if (board.span(eff_rows, MAX_ROWS) * board.span(eff_cols, MAX_COLS) > 96) begin
				which = 0;
			end
			if (which != 2) begin
				write_reg(REG_GRID_ROWS, rows);
			end
			if (which != 1) begin
				write_reg(REG_GRID_COLS, cols);
			end

			frame_cells = board.cells_per_frame();
			count = (frame_cells >= 32) ? frame_cells : frame_cells * $urandom_range(1, 3);
			if (frame_cells > 1 && $urandom_range(0, 3) == 0) begin
				count += $urandom_range(1, frame_cells - 1);
			end
			if (count > TARGET_CELLS - sent) begin
				count = TARGET_CELLS - sent;
			end
			mode = $urandom_range(0, 2);
			gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = 0;
			repeat (count) feed_cell(pick_height(mode));
			sent += count;
			phase++;
			settle();
		end

		if (board.errors == 0 && board.due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
